[rtl/khm_pkg.sv]
package khm_pkg;

  // Widths of the configuration registers and of the configuration port.
  localparam int unsigned RUN_COUNT_W  = 5;
  localparam int unsigned RUN_LENGTH_W = 11;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned CFG_IDX_W    = 1;

  // Register values after reset.
  localparam logic [RUN_COUNT_W-1:0]  RUN_COUNT_RST  = 5'd2;
  localparam logic [RUN_LENGTH_W-1:0] RUN_LENGTH_RST = 11'd1024;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_COUNT  = 1'b0,
    CFG_RUN_LENGTH = 1'b1
  } cfg_idx_e;

  // Command codes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_POP  = 1'b1
  } op_e;

endpackage

[rtl/khm_ram.sv]
module khm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/kway_heap_merge_unit.sv]
// K-way merge of sorted runs through a min-heap of run heads.
// Commands enter on start_i/operation_i/value_i and are taken when start_i is
// high and busy_o is low. A load (operation 0) writes the next element of the
// element store, unless a merge is under way or the store is full, and never
// raises busy_o. A pop (operation 1) returns one transaction on the result
// ports, marked by res_valid_o for one cycle; the receiver cannot stall, so
// results are simply presented. A pop's result is registered in state S_POP;
// the empty answer is registered in the cycle after the pop is taken. A pop
// then keeps busy_o high while the heap is repaired, unless it was empty or
// took the last head: per heap level, read both children (registered read),
// then compare and write. The first pop of a merge also builds the heap,
// inserting the run heads one by one with a sift-up. Configuration writes
// (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once; the user must make
// them only while no command is in progress; the block does not enforce this.
// Reset clears the load count, heap size and merge state; the element store
// and heap memory hold no reset value and need no clearing pass.
module kway_heap_merge_unit #(
  parameter int unsigned MAX_RUNS       = 16,
  parameter int unsigned MAX_RUN_LENGTH = 1024,
  parameter int unsigned DATA_WIDTH     = 32,
  localparam int unsigned RUN_W = $clog2(MAX_RUNS),
  localparam int unsigned POS_W = (MAX_RUN_LENGTH > 1) ? $clog2(MAX_RUN_LENGTH) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic signed [DATA_WIDTH-1:0]        value_i,
  input  logic                                cfg_we_i,
  input  logic [khm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [khm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                res_valid_o,
  output logic signed [DATA_WIDTH-1:0]        value_res_o,
  output logic [RUN_W-1:0]                    source_run_o,
  output logic [POS_W-1:0]                    source_position_o,
  output logic                                last_of_merge_o,
  output logic                                empty_res_o
);

  localparam int unsigned STORE_DEPTH = MAX_RUNS * MAX_RUN_LENGTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned HIDX_W      = $clog2(MAX_RUNS);
  localparam int unsigned SIZE_W      = $clog2(MAX_RUNS + 1);
  localparam int unsigned RC_W        = $clog2(MAX_RUNS + 1);
  localparam int unsigned LEN_W       = $clog2(MAX_RUN_LENGTH + 1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [RUN_W-1:0]             run;
    logic [POS_W-1:0]             pos;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_INS,
    S_UP_CHK,
    S_UP_CMP,
    S_POP,
    S_REFILL_LD,
    S_LAST_LD,
    S_DN_CHK,
    S_DN_CMP
  } state_e;

  // Heap order: smaller value first, lower run on a tie.
  function automatic logic node_less(node_t a, node_t b);
    logic res;
    if (a.value != b.value) begin
      res = (a.value < b.value);
    end else begin
      res = (a.run < b.run);
    end
    return res;
  endfunction

  state_e                           state_q;
  logic [khm_pkg::RUN_COUNT_W-1:0]  run_count_q;
  logic [khm_pkg::RUN_LENGTH_W-1:0] run_length_q;
  logic [CNT_W-1:0]                 loaded_q;
  logic                             merge_started_q;
  logic [SIZE_W-1:0]                heap_size_q;
  logic [RUN_W-1:0]                 run_idx_q;
  logic [CNT_W-1:0]                 base_q;
  logic [HIDX_W-1:0]                hole_q;
  logic                             r_ok_q;
  node_t                            x_q;
  node_t                            top_q;
  logic                             res_valid_q;
  logic signed [DATA_WIDTH-1:0]     value_res_q;
  logic [RUN_W-1:0]                 source_run_q;
  logic [POS_W-1:0]                 source_position_q;
  logic                             last_of_merge_q;
  logic                             empty_res_q;

  logic [RC_W-1:0]       rc_eff;
  logic [LEN_W-1:0]      rl_eff;
  logic [CNT_W-1:0]      load_limit;
  logic                  accept;
  logic                  is_pop;
  logic                  restart;
  logic                  refill;
  logic [CNT_W-1:0]      refill_sum;
  logic [HIDX_W-1:0]     parent_idx;
  logic [HIDX_W+1:0]     left_idx;
  logic [HIDX_W+1:0]     right_idx;
  logic                  left_ok;
  logic                  right_ok;
  logic                  use_right;
  node_t                 child;
  logic [HIDX_W-1:0]     child_idx;
  logic                  up_less;
  logic                  dn_less;
  logic                  insert_done;
  logic                  last_run;

  logic                  store_we;
  logic [ADDR_W-1:0]     store_waddr;
  logic [ADDR_W-1:0]     store_raddr;
  logic [DATA_WIDTH-1:0] store_rdata;
  logic                  heap_we;
  logic [HIDX_W-1:0]     heap_waddr;
  node_t                 heap_wdata;
  logic [HIDX_W-1:0]     heap_raddr_a;
  logic [HIDX_W-1:0]     heap_raddr_b;
  logic [NODE_W-1:0]     heap_rdata_a;
  logic [NODE_W-1:0]     heap_rdata_b;
  node_t                 heap_rd_a;
  node_t                 heap_rd_b;

  assign heap_rd_a = node_t'(heap_rdata_a);
  assign heap_rd_b = node_t'(heap_rdata_b);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q  <= khm_pkg::RUN_COUNT_RST;
      run_length_q <= khm_pkg::RUN_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (khm_pkg::cfg_idx_e'(cfg_idx_i))
        khm_pkg::CFG_RUN_COUNT:  run_count_q  <= cfg_wdata_i[khm_pkg::RUN_COUNT_W-1:0];
        khm_pkg::CFG_RUN_LENGTH: run_length_q <= cfg_wdata_i[khm_pkg::RUN_LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Registers saturated into their legal ranges.
  always_comb begin
    if (run_count_q == '0) begin
      rc_eff = RC_W'(1);
    end else if (32'(run_count_q) > MAX_RUNS) begin
      rc_eff = RC_W'(MAX_RUNS);
    end else begin
      rc_eff = RC_W'(run_count_q);
    end
    if (run_length_q == '0) begin
      rl_eff = LEN_W'(1);
    end else if (32'(run_length_q) > MAX_RUN_LENGTH) begin
      rl_eff = LEN_W'(MAX_RUN_LENGTH);
    end else begin
      rl_eff = LEN_W'(run_length_q);
    end
  end

  assign load_limit = CNT_W'(rc_eff) * CNT_W'(rl_eff);

  // Command decode and the pop's refill decision.
  assign accept  = start_i && (state_q == S_IDLE);
  assign is_pop  = (khm_pkg::op_e'(operation_i) == khm_pkg::OP_POP);
  assign restart = merge_started_q && (heap_size_q == '0);
  assign refill  = (32'(top_q.pos) + 32'd1) < 32'(rl_eff);
  assign refill_sum = CNT_W'(top_q.run) * CNT_W'(rl_eff) + CNT_W'(top_q.pos) + CNT_W'(1);

  // Heap index arithmetic around the hole.
  assign parent_idx = HIDX_W'((hole_q - HIDX_W'(1)) >> 1);
  assign left_idx   = {1'b0, hole_q, 1'b1};
  assign right_idx  = left_idx + (HIDX_W+2)'(1);
  assign left_ok    = 32'(left_idx) < 32'(heap_size_q);
  assign right_ok   = 32'(right_idx) < 32'(heap_size_q);
  assign use_right  = r_ok_q && node_less(heap_rd_b, heap_rd_a);
  assign child      = use_right ? heap_rd_b : heap_rd_a;
  assign child_idx  = use_right ? HIDX_W'(right_idx) : HIDX_W'(left_idx);
  assign up_less    = node_less(x_q, heap_rd_a);
  assign dn_less    = node_less(child, x_q);
  assign insert_done = ((state_q == S_UP_CHK) && (hole_q == '0)) ||
                       ((state_q == S_UP_CMP) && !up_less);
  assign last_run   = (32'(run_idx_q) + 32'd1) == 32'(rc_eff);

  // Memory port control.
  always_comb begin
    store_we     = 1'b0;
    store_waddr  = restart ? '0 : ADDR_W'(loaded_q);
    store_raddr  = ADDR_W'(base_q);
    heap_we      = 1'b0;
    heap_waddr   = hole_q;
    heap_wdata   = x_q;
    heap_raddr_a = '0;
    heap_raddr_b = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !is_pop) begin
          store_we = restart || (!merge_started_q && (loaded_q < load_limit));
        end
      end
      S_POP: begin
        store_raddr  = ADDR_W'(refill_sum);
        heap_raddr_a = HIDX_W'(heap_size_q - SIZE_W'(1));
      end
      S_UP_CHK: begin
        if (hole_q == '0) begin
          heap_we = 1'b1;
        end else begin
          heap_raddr_a = parent_idx;
        end
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        if (up_less) begin
          heap_wdata = heap_rd_a;
        end
      end
      S_DN_CHK: begin
        if (!left_ok) begin
          heap_we = 1'b1;
        end else begin
          heap_raddr_a = HIDX_W'(left_idx);
          heap_raddr_b = HIDX_W'(right_idx);
        end
      end
      S_DN_CMP: begin
        heap_we = 1'b1;
        if (dn_less) begin
          heap_wdata = child;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, heap bookkeeping and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      loaded_q          <= '0;
      merge_started_q   <= 1'b0;
      heap_size_q       <= '0;
      run_idx_q         <= '0;
      base_q            <= '0;
      hole_q            <= '0;
      r_ok_q            <= 1'b0;
      x_q               <= '0;
      top_q             <= '0;
      res_valid_q       <= 1'b0;
      value_res_q       <= '0;
      source_run_q      <= '0;
      source_position_q <= '0;
      last_of_merge_q   <= 1'b0;
      empty_res_q       <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;

      // Keep a copy of the heap root next to the memory.
      if (heap_we && (heap_waddr == '0)) begin
        top_q <= heap_wdata;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_pop) begin
              if (!merge_started_q) begin
                run_idx_q   <= '0;
                base_q      <= '0;
                heap_size_q <= '0;
                state_q     <= S_BUILD_RD;
              end else if (heap_size_q == '0) begin
                res_valid_q       <= 1'b1;
                value_res_q       <= '0;
                source_run_q      <= '0;
                source_position_q <= '0;
                last_of_merge_q   <= 1'b0;
                empty_res_q       <= 1'b1;
              end else begin
                state_q <= S_POP;
              end
            end else if (restart) begin
              merge_started_q <= 1'b0;
              loaded_q        <= CNT_W'(1);
            end else if (!merge_started_q && (loaded_q < load_limit)) begin
              loaded_q <= loaded_q + CNT_W'(1);
            end
          end
        end
        S_BUILD_RD: begin
          state_q <= S_BUILD_INS;
        end
        S_BUILD_INS: begin
          x_q     <= '{value: $signed(store_rdata), run: run_idx_q, pos: '0};
          hole_q  <= HIDX_W'(heap_size_q);
          state_q <= S_UP_CHK;
        end
        S_UP_CHK: begin
          if (hole_q != '0) begin
            state_q <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_less) begin
            hole_q  <= parent_idx;
            state_q <= S_UP_CHK;
          end
        end
        S_POP: begin
          res_valid_q       <= 1'b1;
          value_res_q       <= top_q.value;
          source_run_q      <= top_q.run;
          source_position_q <= top_q.pos;
          empty_res_q       <= 1'b0;
          if (refill) begin
            last_of_merge_q <= 1'b0;
            state_q         <= S_REFILL_LD;
          end else begin
            heap_size_q     <= heap_size_q - SIZE_W'(1);
            last_of_merge_q <= (heap_size_q == SIZE_W'(1));
            state_q         <= (heap_size_q == SIZE_W'(1)) ? S_IDLE : S_LAST_LD;
          end
        end
        S_REFILL_LD: begin
          x_q     <= '{value: $signed(store_rdata), run: top_q.run,
                       pos: POS_W'(top_q.pos + POS_W'(1))};
          hole_q  <= '0;
          state_q <= S_DN_CHK;
        end
        S_LAST_LD: begin
          x_q     <= heap_rd_a;
          hole_q  <= '0;
          state_q <= S_DN_CHK;
        end
        S_DN_CHK: begin
          r_ok_q  <= right_ok;
          state_q <= left_ok ? S_DN_CMP : S_IDLE;
        end
        S_DN_CMP: begin
          if (dn_less) begin
            hole_q  <= child_idx;
            state_q <= S_DN_CHK;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // A finished insertion moves on to the next run head.
      if (insert_done) begin
        heap_size_q <= heap_size_q + SIZE_W'(1);
        base_q      <= base_q + CNT_W'(rl_eff);
        run_idx_q   <= RUN_W'(32'(run_idx_q) + 32'd1);
        if (last_run) begin
          merge_started_q <= 1'b1;
          state_q         <= S_POP;
        end else begin
          state_q <= S_BUILD_RD;
        end
      end
    end
  end

  khm_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (store_we),
    .waddr_i  (store_waddr),
    .wdata_i  (value_i),
    .raddr_a_i(store_raddr),
    .rdata_a_o(store_rdata),
    .raddr_b_i('0),
    .rdata_b_o()
  );

  khm_ram #(
    .WIDTH(NODE_W),
    .DEPTH(MAX_RUNS)
  ) u_heap (
    .clk_i    (clk_i),
    .we_i     (heap_we),
    .waddr_i  (heap_waddr),
    .wdata_i  (heap_wdata),
    .raddr_a_i(heap_raddr_a),
    .rdata_a_o(heap_rdata_a),
    .raddr_b_i(heap_raddr_b),
    .rdata_b_o(heap_rdata_b)
  );

  assign busy_o            = (state_q != S_IDLE);
  assign res_valid_o       = res_valid_q;
  assign value_res_o       = value_res_q;
  assign source_run_o      = source_run_q;
  assign source_position_o = source_position_q;
  assign last_of_merge_o   = last_of_merge_q;
  assign empty_res_o       = empty_res_q;

  // An empty answer is only given once a started merge has drained.
  a_empty_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && empty_res_q |-> merge_started_q && (heap_size_q == '0))
    else $error("empty result while heads remain");

  // The final merged element leaves the heap empty.
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && last_of_merge_q |-> heap_size_q == '0)
    else $error("last_of_merge with heads left");

  // The sift-down hole always lies inside the live heap.
  a_hole_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DN_CHK |-> 32'(hole_q) < 32'(heap_size_q))
    else $error("sift-down hole outside heap");

  // A result follows only a pop that was taken or an empty-heap pop.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == S_POP || (accept && is_pop)))
    else $error("result without a pop");

endmodule

[sim/kway_heap_merge_unit_test.sv]
`timescale 1ns / 1ps

module kway_heap_merge_unit_test;
  import khm_pkg::*;

  localparam int RUNS    = 16;
  localparam int RUN_LEN = 1024;
  localparam int DW      = 32;
  localparam int DEPTH   = RUNS * RUN_LEN;
  // Idle cycles required before a register write once all results are in.
  localparam int SETTLE  = 16;

  typedef enum logic [1:0] {
    ACT_CMD,
    ACT_CFG,
    ACT_SYNC,
    ACT_MODE
  } act_kind_e;

  // One pending stimulus step: a command, a register write, a drain point
  // or a change of the sender idle rate.
  typedef struct {
    act_kind_e          kind;
    op_e                op;
    logic signed [31:0] value;
    cfg_idx_e           idx;
    logic [10:0]        data;
    int                 pct;
  } merge_act_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         run;
    logic [9:0]         pos;
    logic               last;
    logic               empty;
  } merge_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic                         busy_o;
  logic                         operation_i = OP_LOAD;
  logic signed [DW-1:0]         value_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i = CFG_RUN_COUNT;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i = '0;
  logic                         res_valid_o;
  logic signed [DW-1:0]         value_res_o;
  logic [3:0]                   source_run_o;
  logic [9:0]                   source_position_o;
  logic                         last_of_merge_o;
  logic                         empty_res_o;

  kway_heap_merge_unit #(
    .MAX_RUNS      (RUNS),
    .MAX_RUN_LENGTH(RUN_LEN),
    .DATA_WIDTH    (DW)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .value_i          (value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .res_valid_o      (res_valid_o),
    .value_res_o      (value_res_o),
    .source_run_o     (source_run_o),
    .source_position_o(source_position_o),
    .last_of_merge_o  (last_of_merge_o),
    .empty_res_o      (empty_res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus queue and expected merge output.
  merge_act_t    act_q[$];
  merge_result_t merge_expect_q[$];

  // Shadow copy of the merge state.
  logic signed [31:0] elem_mem [0:DEPTH-1];
  int                 head_ptr [0:RUNS-1];
  logic signed [31:0] heap_val [0:RUNS-1];
  int                 heap_run [0:RUNS-1];
  int                 heap_cnt = 0;
  int                 load_cnt = 0;
  bit                 merging = 1'b0;
  logic [RUN_COUNT_W-1:0]  cfg_runs = RUN_COUNT_RST;
  logic [RUN_LENGTH_W-1:0] cfg_len  = RUN_LENGTH_RST;

  int  err_count = 0;
  int  loads_stored = 0;
  int  pops_seen = 0;
  int  empties_seen = 0;
  int  sessions = 0;
  int  idle_pct = 0;
  int  settle_cnt = 0;
  bit  cmd_taken = 1'b0;

  function automatic int eff_runs();
    if (cfg_runs == 0) return 1;
    if (cfg_runs > RUNS) return RUNS;
    return int'(cfg_runs);
  endfunction

  function automatic int eff_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > RUN_LEN) return RUN_LEN;
    return int'(cfg_len);
  endfunction

  // Heap order: smaller value first, lower run on a tie.
  function automatic bit heap_less(int a, int b);
    if (heap_val[a] != heap_val[b]) return heap_val[a] < heap_val[b];
    return heap_run[a] < heap_run[b];
  endfunction

  function automatic void heap_swap(int a, int b);
    logic signed [31:0] v;
    int                 r;
    v = heap_val[a];
    r = heap_run[a];
    heap_val[a] = heap_val[b];
    heap_run[a] = heap_run[b];
    heap_val[b] = v;
    heap_run[b] = r;
  endfunction

  function automatic void heap_sift_up(int i);
    int  p;
    bit  done;
    done = 1'b0;
    while (i > 0 && !done) begin
      p = (i - 1) / 2;
      if (heap_less(i, p)) begin
        heap_swap(i, p);
        i = p;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  function automatic void heap_sift_down(int i);
    int  l;
    int  r;
    int  m;
    bit  done;
    done = 1'b0;
    while (!done) begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      m = i;
      if (l < heap_cnt && heap_less(l, m)) m = l;
      if (r < heap_cnt && heap_less(r, m)) m = r;
      if (m == i) begin
        done = 1'b1;
      end else begin
        heap_swap(i, m);
        i = m;
      end
    end
  endfunction

  // Work out what one accepted command does and queue any result it causes.
  task automatic predict_merge(input op_e op, input logic signed [31:0] val);
    int            rc;
    int            rl;
    int            r;
    int            pos;
    merge_result_t res;
    rc = eff_runs();
    rl = eff_len();
    if (op == OP_LOAD) begin
      // A load after a finished merge opens a new session; one during a merge is dropped.
      if (merging && heap_cnt == 0) begin
        merging = 1'b0;
        load_cnt = 0;
      end
      if (!merging && load_cnt < rc * rl) begin
        elem_mem[load_cnt] = val;
        load_cnt++;
        loads_stored++;
      end
    end else begin
      pops_seen++;
      // The first pop of a session builds the heap of run heads.
      if (!merging) begin
        heap_cnt = 0;
        for (r = 0; r < rc; r++) begin
          head_ptr[r] = 0;
          heap_val[heap_cnt] = elem_mem[r * rl];
          heap_run[heap_cnt] = r;
          heap_cnt++;
          heap_sift_up(heap_cnt - 1);
        end
        merging = 1'b1;
      end
      res = '0;
      if (heap_cnt == 0) begin
        res.empty = 1'b1;
        empties_seen++;
      end else begin
        r = heap_run[0];
        res.value = heap_val[0];
        pos = head_ptr[r];
        // Refill from the same run, or retire the run once it is used up.
        if (pos + 1 < rl) begin
          head_ptr[r] = pos + 1;
          heap_val[0] = elem_mem[r * rl + pos + 1];
        end else begin
          heap_cnt--;
          heap_val[0] = heap_val[heap_cnt];
          heap_run[0] = heap_run[heap_cnt];
        end
        heap_sift_down(0);
        res.run = r[3:0];
        res.pos = pos[9:0];
        res.last = (heap_cnt == 0);
      end
      merge_expect_q.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Compare one result transaction with the oldest expectation.
  task automatic check_result();
    merge_result_t want;
    if (merge_expect_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, value %0d run %0d",
                                value_res_o, source_run_o));
    end else begin
      want = merge_expect_q.pop_front();
      if (value_res_o !== want.value)
        report_mismatch($sformatf("value %0d, expected %0d", value_res_o, want.value));
      if (source_run_o !== want.run)
        report_mismatch($sformatf("run %0d, expected %0d", source_run_o, want.run));
      if (source_position_o !== want.pos)
        report_mismatch($sformatf("position %0d, expected %0d", source_position_o, want.pos));
      if (last_of_merge_o !== want.last)
        report_mismatch($sformatf("last flag %0b, expected %0b", last_of_merge_o, want.last));
      if (empty_res_o !== want.empty)
        report_mismatch($sformatf("empty flag %0b, expected %0b", empty_res_o, want.empty));
    end
  endtask

  // Monitor: register writes, accepted commands and result transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cmd_taken = start_i && !busy_o;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RUN_COUNT) cfg_runs = cfg_wdata_i[RUN_COUNT_W-1:0];
        else cfg_len = cfg_wdata_i[RUN_LENGTH_W-1:0];
      end
      if (cmd_taken) predict_merge(op_e'(operation_i), value_i);
      if (res_valid_o) check_result();
    end
  end

  // Driver: works through the stimulus queue, at most one step per falling edge, holding a command until it is taken.
  always @(negedge clk_i) begin : drive_proc
    merge_act_t cur;
    logic       nxt_start;
    logic       nxt_we;
    if (rst_ni) begin
      nxt_start = 1'b0;
      nxt_we = 1'b0;
      if (start_i && !cmd_taken) begin
        nxt_start = 1'b1;
      end else if (act_q.size() > 0) begin
        cur = act_q[0];
        case (cur.kind)
          ACT_MODE: begin
            idle_pct = cur.pct;
            void'(act_q.pop_front());
          end
          // Hold off until every result is in and the block has gone quiet.
          ACT_SYNC: begin
            if (merge_expect_q.size() == 0 && !busy_o) begin
              settle_cnt++;
              if (settle_cnt >= SETTLE) begin
                settle_cnt = 0;
                void'(act_q.pop_front());
              end
            end else begin
              settle_cnt = 0;
            end
          end
          ACT_CFG: begin
            nxt_we = 1'b1;
            cfg_idx_i <= cur.idx;
            cfg_wdata_i <= cur.data;
            void'(act_q.pop_front());
          end
          default: begin
            if ($urandom_range(0, 99) >= idle_pct) begin
              nxt_start = 1'b1;
              operation_i <= cur.op;
              value_i <= cur.value;
              void'(act_q.pop_front());
            end
          end
        endcase
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  task automatic push_cmd(input op_e op, input logic signed [31:0] v);
    merge_act_t a;
    a.kind = ACT_CMD;
    a.op = op;
    a.value = v;
    a.idx = CFG_RUN_COUNT;
    a.data = '0;
    a.pct = 0;
    act_q.push_back(a);
  endtask

  // Every register write waits for the block to drain first.
  task automatic push_cfg(input cfg_idx_e idx, input int data);
    merge_act_t a;
    a.kind = ACT_SYNC;
    a.op = OP_LOAD;
    a.value = '0;
    a.idx = idx;
    a.data = data[10:0];
    a.pct = 0;
    act_q.push_back(a);
    a.kind = ACT_CFG;
    act_q.push_back(a);
  endtask

  task automatic push_mode(input int pct);
    merge_act_t a;
    a.kind = ACT_MODE;
    a.op = OP_LOAD;
    a.value = '0;
    a.idx = CFG_RUN_COUNT;
    a.data = '0;
    a.pct = pct;
    act_q.push_back(a);
  endtask

  // Wait until the driver has issued everything queued so far.
  task automatic drain_actions();
    while (act_q.size() != 0 || start_i || cfg_we_i) @(posedge clk_i);
  endtask

  // Load nruns sorted runs of len values each, with varied spreads and ties.
  task automatic push_runs(input int nruns, input int len);
    logic signed [31:0] v;
    int                 r;
    int                 p;
    int                 kind;
    int                 step;
    for (r = 0; r < nruns; r++) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 3)) - 2;
        2: v = 32'sh8000_0000 + $urandom_range(0, 3);
        default: v = 32'sh7FFF_FFFF - 3 * len;
      endcase
      for (p = 0; p < len; p++) begin
        push_cmd(OP_LOAD, v);
        step = (kind == 0) ? $urandom_range(0, 1 << 20) : $urandom_range(0, 3);
        v = v + step;
      end
    end
  endtask

  // Empty the heap so the next load starts a fresh session: with a run length
  // of one, every pop retires one run head.
  task automatic end_merge();
    int n;
    drain_actions();
    if (merging ? (heap_cnt > 0) : (load_cnt > 0)) begin
      n = merging ? heap_cnt : eff_runs();
      push_cfg(CFG_RUN_LENGTH, 1);
      repeat (n) push_cmd(OP_POP, $urandom);
    end
  endtask

  // One random merge session: configuration, loads and pops.
  task automatic random_session();
    int sel;
    int rc_raw;
    int rl_raw;
    int rc;
    int rl;
    int n_pop;
    int i;
    end_merge();
    sessions++;
    sel = $urandom_range(0, 19);
    if (sel == 0) rc_raw = $urandom_range(17, 31);
    else if (sel == 1) rc_raw = 0;
    else if (sel == 2) rc_raw = RUNS;
    else rc_raw = $urandom_range(1, 5);
    sel = $urandom_range(0, 19);
    if (sel == 0) rl_raw = $urandom_range(1025, 2047);
    else if (sel == 1) rl_raw = 0;
    else if (sel == 2) rl_raw = $urandom_range(17, 1024);
    else rl_raw = $urandom_range(1, 6);
    // Upper data bits are don't-care for the run count register.
    push_cfg(CFG_RUN_COUNT, ($urandom_range(0, 63) << 5) | rc_raw);
    push_cfg(CFG_RUN_LENGTH, rl_raw);
    rc = (rc_raw == 0) ? 1 : ((rc_raw > RUNS) ? RUNS : rc_raw);
    rl = (rl_raw == 0) ? 1 : ((rl_raw > RUN_LEN) ? RUN_LEN : rl_raw);
    if (rl <= 16 && rc * rl <= 48) begin
      // Well-formed session, with occasional excess loads, early stops and
      // loads dropped into the middle of the merge.
      push_runs(rc, rl);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) push_cmd(OP_LOAD, $urandom);
      if ($urandom_range(0, 7) == 0) n_pop = $urandom_range(1, rc * rl);
      else n_pop = rc * rl + $urandom_range(0, 2);
      for (i = 0; i < n_pop; i++) begin
        push_cmd(OP_POP, $urandom);
        if ($urandom_range(0, 15) == 0) push_cmd(OP_LOAD, $urandom);
      end
    end else begin
      // Large sizes: a short load followed by a few pops.
      repeat ($urandom_range(0, 12)) push_cmd(OP_LOAD, $urandom);
      repeat ($urandom_range(1, 12)) push_cmd(OP_POP, $urandom);
    end
  endtask

  initial begin
    int base;
    int ph;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole element store at the largest size, then a few excess loads.
    push_mode(10);
    push_cfg(CFG_RUN_COUNT, RUNS);
    push_cfg(CFG_RUN_LENGTH, RUN_LEN);
    push_runs(RUNS, RUN_LEN);
    repeat (3) push_cmd(OP_LOAD, $urandom);

    // Partial merge of sixteen runs, a dropped load, a mid-merge length change
    // down to one, then pops on an empty heap.
    repeat (4) push_cmd(OP_POP, $urandom);
    push_cmd(OP_LOAD, 32'sh1234_5678);
    end_merge();
    push_cmd(OP_POP, $urandom);
    push_cmd(OP_POP, $urandom);

    // Extreme values with ties across runs.
    push_cfg(CFG_RUN_COUNT, 11'h7E3);
    push_cfg(CFG_RUN_LENGTH, 2);
    push_cmd(OP_LOAD, 32'sh8000_0000);
    push_cmd(OP_LOAD, 32'sd5);
    push_cmd(OP_LOAD, 32'sh8000_0000);
    push_cmd(OP_LOAD, 32'sh7FFF_FFFF);
    push_cmd(OP_LOAD, 32'sd5);
    push_cmd(OP_LOAD, 32'sh7FFF_FFFF);
    repeat (7) push_cmd(OP_POP, $urandom);

    // Zero registers clamp to one run of one element.
    push_cfg(CFG_RUN_COUNT, 0);
    push_cfg(CFG_RUN_LENGTH, 0);
    push_cmd(OP_LOAD, -32'sd1);
    repeat (2) push_cmd(OP_POP, $urandom);

    // Oversized registers clamp to the maximum; short load then pops.
    push_cfg(CFG_RUN_COUNT, 31);
    push_cfg(CFG_RUN_LENGTH, 2047);
    repeat (3) push_cmd(OP_LOAD, $urandom);
    repeat (2) push_cmd(OP_POP, $urandom);
    drain_actions();

    // Random sessions under three sender idle rates.
    base = loads_stored + pops_seen;
    for (ph = 0; ph < 3; ph++) begin
      push_mode((ph == 0) ? 10 : ((ph == 1) ? 88 : 0));
      while (loads_stored + pops_seen - base < 170 * (ph + 1)) random_session();
    end
    end_merge();
    drain_actions();

    while (merge_expect_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Run covered %0d stored loads and %0d pops, %0d of them on an empty heap,",
             loads_stored, pops_seen, empties_seen);
    $display("over %0d random merge sessions with clamped register values and idle gaps.",
             sessions);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
